>>> rtl/rwsp_pkg.sv
// ----------------------------------------------------------------------------
// rwsp_pkg
// Shared constants and types of the RIFF WAVE stream parser.
// ----------------------------------------------------------------------------
package rwsp_pkg;

   // chunk tags as they land in a little-endian shift register
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] FORMAT_PCM      = 16'h0001;
   localparam logic [15:0] NEEDED_CHANNELS = 16'd2;
   localparam logic [14:0] NEEDED_HALF_ALIGN = 15'd2;

   // parser phases
   localparam logic [1:0] PH_RIFF = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_STOP = 2'd3;

   // result event codes
   localparam logic [3:0] EV_AUDIO        = 4'd0;
   localparam logic [3:0] EV_PLAY_START   = 4'd1;
   localparam logic [3:0] EV_NOT_RIFF     = 4'd2;
   localparam logic [3:0] EV_NOT_WAVE     = 4'd3;
   localparam logic [3:0] EV_BAD_TAG      = 4'd4;
   localparam logic [3:0] EV_BAD_CHANNELS = 4'd5;
   localparam logic [3:0] EV_BAD_BITS     = 4'd6;
   localparam logic [3:0] EV_NO_FMT       = 4'd7;
   localparam logic [3:0] EV_FILE_END     = 4'd8;

   // depth of the result queue, room for two full bytes' worth of results
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [7:0]  audio_byte;
      logic [31:0] sample_rate;
      logic        last_of_run;
   } res_type;

   // results produced by one accepted byte
   typedef struct packed {
      logic [1:0] count;
      res_type    r0;
      res_type    r1;
   } push_type;

endpackage

>>> rtl/rwsp_parser.sv
// ----------------------------------------------------------------------------
// rwsp_parser
// Header and chunk walker: state registers plus one step of next-state logic
// per accepted byte, producing up to two results.
// ----------------------------------------------------------------------------
module rwsp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         din,
   output rwsp_pkg::push_type push
);

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] file_offset_ff, file_offset_in;
   logic [31:0] riff_size_ff, riff_size_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] chunk_remaining_ff, chunk_remaining_in;
   logic [15:0] format_tag_ff, format_tag_in;
   logic [15:0] channel_count_ff, channel_count_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] block_align_ff, block_align_in;
   logic        format_seen_ff, format_seen_in;
   logic        playing_ff, playing_in;

   logic [31:0] off_inc;
   logic        bnd;
   logic        ev_vld;
   logic [3:0]  ev_code;
   logic [7:0]  ev_byte;
   logic [31:0] ev_rate;
   logic        end_vld;
   rwsp_pkg::res_type res_a, res_e;

   always_comb begin
      phase_in           = phase_ff;
      idx_in             = idx_ff;
      file_offset_in     = file_offset_ff;
      riff_size_in       = riff_size_ff;
      chunk_tag_in       = chunk_tag_ff;
      chunk_remaining_in = chunk_remaining_ff;
      format_tag_in      = format_tag_ff;
      channel_count_in   = channel_count_ff;
      rate_in            = rate_ff;
      block_align_in     = block_align_ff;
      format_seen_in     = format_seen_ff;
      playing_in         = playing_ff;
      off_inc            = (file_offset_ff == 32'hFFFF_FFFF) ? file_offset_ff
                                                             : file_offset_ff + 32'd1;
      bnd     = 1'b0;
      ev_vld  = 1'b0;
      ev_code = rwsp_pkg::EV_AUDIO;
      ev_byte = 8'd0;
      ev_rate = 32'd0;
      end_vld = 1'b0;

      if (accept && phase_ff != rwsp_pkg::PH_STOP) begin
         file_offset_in = off_inc;
         case (phase_ff)
            rwsp_pkg::PH_RIFF: begin
               if (idx_ff < 4'd4 || idx_ff >= 4'd8) begin
                  chunk_tag_in = {din, chunk_tag_ff[31:8]};
               end else begin
                  riff_size_in = {din, riff_size_ff[31:8]};
               end
               if (idx_ff == 4'd3 && chunk_tag_in != rwsp_pkg::TAG_RIFF) begin
                  ev_vld   = 1'b1;
                  ev_code  = rwsp_pkg::EV_NOT_RIFF;
                  phase_in = rwsp_pkg::PH_STOP;
               end else if (idx_ff >= 4'd11) begin
                  if (chunk_tag_in != rwsp_pkg::TAG_WAVE) begin
                     ev_vld   = 1'b1;
                     ev_code  = rwsp_pkg::EV_NOT_WAVE;
                     phase_in = rwsp_pkg::PH_STOP;
                  end else begin
                     bnd = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            rwsp_pkg::PH_HDR: begin
               if (idx_ff < 4'd4) begin
                  chunk_tag_in = {din, chunk_tag_ff[31:8]};
               end else begin
                  chunk_remaining_in = {din, chunk_remaining_ff[31:8]};
               end
               if (idx_ff >= 4'd7) begin
                  idx_in = 4'd0;
                  if (chunk_tag_in == rwsp_pkg::TAG_FMT) begin
                     format_tag_in    = 16'd0;
                     channel_count_in = 16'd0;
                     rate_in          = 32'd0;
                     block_align_in   = 16'd0;
                     format_seen_in   = 1'b1;
                  end else if (chunk_tag_in == rwsp_pkg::TAG_DATA) begin
                     ev_vld = 1'b1;
                     if (!format_seen_ff) begin
                        ev_code = rwsp_pkg::EV_NO_FMT;
                     end else if (format_tag_ff != rwsp_pkg::FORMAT_PCM) begin
                        ev_code = rwsp_pkg::EV_BAD_TAG;
                     end else if (channel_count_ff != rwsp_pkg::NEEDED_CHANNELS) begin
                        ev_code = rwsp_pkg::EV_BAD_CHANNELS;
                     end else if (block_align_ff[15:1] != rwsp_pkg::NEEDED_HALF_ALIGN) begin
                        ev_code = rwsp_pkg::EV_BAD_BITS;
                     end else begin
                        ev_code    = rwsp_pkg::EV_PLAY_START;
                        ev_rate    = rate_ff;
                        playing_in = 1'b1;
                     end
                  end
                  if (chunk_remaining_in == 32'd0) begin
                     bnd = 1'b1;
                  end else begin
                     phase_in = rwsp_pkg::PH_BODY;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            rwsp_pkg::PH_BODY: begin
               if (chunk_tag_ff == rwsp_pkg::TAG_FMT) begin
                  case (idx_ff)
                     4'd0:    format_tag_in[7:0]     = din;
                     4'd1:    format_tag_in[15:8]    = din;
                     4'd2:    channel_count_in[7:0]  = din;
                     4'd3:    channel_count_in[15:8] = din;
                     4'd4:    rate_in[7:0]           = din;
                     4'd5:    rate_in[15:8]          = din;
                     4'd6:    rate_in[23:16]         = din;
                     4'd7:    rate_in[31:24]         = din;
                     4'd12:   block_align_in[7:0]    = din;
                     4'd13:   block_align_in[15:8]   = din;
                     default: ;
                  endcase
               end
               if (playing_ff) begin
                  ev_vld  = 1'b1;
                  ev_code = rwsp_pkg::EV_AUDIO;
                  ev_byte = din;
               end
               if (idx_ff != 4'd15) begin
                  idx_in = idx_ff + 4'd1;
               end
               chunk_remaining_in = chunk_remaining_ff - 32'd1;
               bnd = (chunk_remaining_in == 32'd0);
            end
            default: ;
         endcase

         // chunk boundary: end of file test against riff size plus 8
         if (bnd) begin
            playing_in = 1'b0;
            idx_in     = 4'd0;
            if ({1'b0, off_inc} >= {1'b0, riff_size_in} + 33'd8) begin
               end_vld        = 1'b1;
               phase_in       = rwsp_pkg::PH_RIFF;
               file_offset_in = 32'd0;
            end else begin
               phase_in = rwsp_pkg::PH_HDR;
            end
         end
      end
   end

   always_comb begin
      res_a.event_res   = ev_code;
      res_a.audio_byte  = ev_byte;
      res_a.sample_rate = ev_rate;
      res_a.last_of_run = !end_vld;
      res_e.event_res   = rwsp_pkg::EV_FILE_END;
      res_e.audio_byte  = 8'd0;
      res_e.sample_rate = 32'd0;
      res_e.last_of_run = 1'b1;
      push.count = {1'b0, ev_vld} + {1'b0, end_vld};
      push.r0    = ev_vld ? res_a : res_e;
      push.r1    = res_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= rwsp_pkg::PH_RIFF;
         idx_ff             <= 4'd0;
         file_offset_ff     <= 32'd0;
         riff_size_ff       <= 32'd0;
         chunk_tag_ff       <= 32'd0;
         chunk_remaining_ff <= 32'd0;
         format_tag_ff      <= 16'd0;
         channel_count_ff   <= 16'd0;
         rate_ff            <= 32'd0;
         block_align_ff     <= 16'd0;
         format_seen_ff     <= 1'b0;
         playing_ff         <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         idx_ff             <= idx_in;
         file_offset_ff     <= file_offset_in;
         riff_size_ff       <= riff_size_in;
         chunk_tag_ff       <= chunk_tag_in;
         chunk_remaining_ff <= chunk_remaining_in;
         format_tag_ff      <= format_tag_in;
         channel_count_ff   <= channel_count_in;
         rate_ff            <= rate_in;
         block_align_ff     <= block_align_in;
         format_seen_ff     <= format_seen_in;
         playing_ff         <= playing_in;
      end
   end

   // a header error is sticky until reset
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rwsp_pkg::PH_STOP |=> phase_ff == rwsp_pkg::PH_STOP)
      else $error("parser left the stopped phase");

   // payload pass-through only inside a chunk body
   a_play_in_body: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> phase_ff == rwsp_pkg::PH_BODY)
      else $error("playing outside a chunk body");

   // the riff header is twelve bytes
   a_riff_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rwsp_pkg::PH_RIFF |-> idx_ff <= 4'd11)
      else $error("riff header index out of range");

   // play start only once a fmt chunk has been seen
   a_play_needs_fmt: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> format_seen_ff)
      else $error("playing without a fmt chunk");

endmodule

>>> rtl/rwsp_res_queue.sv
// ----------------------------------------------------------------------------
// rwsp_res_queue
// Small result queue: takes up to two results per cycle while room is high, hands out one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
module rwsp_res_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   input  rwsp_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rwsp_pkg::res_type  head
);

   localparam int PtrW = $clog2(rwsp_pkg::QUEUE_DEPTH);
   localparam int CntW = PtrW + 1;

   rwsp_pkg::res_type entry_ff [rwsp_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] push_n;
   logic            pop;

   assign push_n    = push_en ? CntW'(push.count) : '0;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   // two free entries needed for the worst case byte
   assign room      = (count_ff <= CntW'(rwsp_pkg::QUEUE_DEPTH - 2));
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + push_n - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push_n == CntW'(2)) begin
         entry_ff[wr_ptr_ff + PtrW'(1)] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(rwsp_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      PtrW'(wr_ptr_ff - rd_ptr_ff) == PtrW'(count_ff))
      else $error("result queue pointers disagree with count");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push_n != '0 |-> count_ff + push_n <= CntW'(rwsp_pkg::QUEUE_DEPTH) + CntW'(pop))
      else $error("push without room");

endmodule

>>> rtl/riff_wave_stream_parser.sv
// ----------------------------------------------------------------------------
// riff_wave_stream_parser
// Byte-wide RIFF WAVE parser reporting play start, format errors, payload
// bytes and file end.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the wave file one byte per transaction, in file order.
//   rsp_* carries result transactions; one input byte yields zero, one or two
//   results, and rsp_last_of_run marks the final result of a byte.
//   Latency: the first result of a byte is offered on the cycle after the
//   byte is accepted if the queue was empty, else once earlier results are taken.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and the receiver keeps up; a byte that closes the file with a second
//   result yields a further transaction. Results pass through a four-entry
//   queue, and req_ready stays high while two entries are free, so the
//   input side keeps moving while a result waits to be taken.
//   Stalls: when rsp_ready is held low the queue fills and req_ready drops;
//   no result is lost or repeated.
//   Reset clears the parser to expect a RIFF header and empties the queue.
//   After a "not riff" or "not wave" error every byte is taken and dropped
//   until reset.
// ----------------------------------------------------------------------------
module riff_wave_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_res,
   output logic [7:0]  rsp_audio_byte,
   output logic [31:0] rsp_sample_rate,
   output logic        rsp_last_of_run
);

   logic               accept;
   logic               room;
   rwsp_pkg::push_type push;
   rwsp_pkg::res_type  head;

   assign req_ready = room;
   assign accept    = req_valid && room;

   rwsp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .din    (req_in_byte),
      .push   (push)
   );

   rwsp_res_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_event_res   = head.event_res;
   assign rsp_audio_byte  = head.audio_byte;
   assign rsp_sample_rate = head.sample_rate;
   assign rsp_last_of_run = head.last_of_run;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams RIFF WAVE files byte by byte into the parser and checks every
// result transaction against a parser model kept in step with accepted bytes.
// ----------------------------------------------------------------------------

class wave_event_board;
   rwsp_pkg::res_type pending_results[$];
   int      mismatches;
   int      bytes_seen;
   int      event_tally [0:15];

   // mirror of the parser state
   logic [1:0]  phase;
   logic [3:0]  hdr_idx;
   logic [31:0] offset;
   logic [31:0] riff_len;
   logic [31:0] tag;
   logic [31:0] remaining;
   logic [15:0] fmt_tag;
   logic [15:0] chans;
   logic [31:0] rate;
   logic [15:0] align;
   logic        fmt_seen;
   logic        playing;

   function new();
      phase = rwsp_pkg::PH_RIFF;
      hdr_idx = '0;
      offset = '0;
      riff_len = '0;
      tag = '0;
      remaining = '0;
      fmt_tag = '0;
      chans = '0;
      rate = '0;
      align = '0;
      fmt_seen = 1'b0;
      playing = 1'b0;
      mismatches = 0;
      bytes_seen = 0;
      foreach (event_tally[i]) event_tally[i] = 0;
   endfunction

   function void add_result(logic [3:0] ev, logic [7:0] data, logic [31:0] sps);
      rwsp_pkg::res_type r;
      r.event_res = ev;
      r.audio_byte = data;
      r.sample_rate = sps;
      r.last_of_run = 1'b0;
      pending_results.push_back(r);
   endfunction

   // end of a chunk: either the file is over or another chunk header follows
   function void close_chunk();
      playing = 1'b0;
      hdr_idx = '0;
      if ({1'b0, offset} >= {1'b0, riff_len} + 33'd8) begin
         add_result(rwsp_pkg::EV_FILE_END, 8'd0, 32'd0);
         phase = rwsp_pkg::PH_RIFF;
         offset = '0;
      end else begin
         phase = rwsp_pkg::PH_HDR;
      end
   endfunction

   function void parse_byte(logic [7:0] b);
      logic [3:0] idx;
      int         first;
      rwsp_pkg::res_type tail;
      idx = hdr_idx;
      first = pending_results.size();
      bytes_seen++;
      if (phase == rwsp_pkg::PH_STOP) return;
      if (offset != 32'hFFFF_FFFF) offset++;
      case (phase)
         rwsp_pkg::PH_RIFF: begin
            if (idx < 4 || idx >= 8) tag = {b, tag[31:8]};
            else riff_len = {b, riff_len[31:8]};
            if (idx == 3 && tag != rwsp_pkg::TAG_RIFF) begin
               add_result(rwsp_pkg::EV_NOT_RIFF, 8'd0, 32'd0);
               phase = rwsp_pkg::PH_STOP;
            end else if (idx >= 11) begin
               if (tag != rwsp_pkg::TAG_WAVE) begin
                  add_result(rwsp_pkg::EV_NOT_WAVE, 8'd0, 32'd0);
                  phase = rwsp_pkg::PH_STOP;
               end else begin
                  close_chunk();
               end
            end else begin
               hdr_idx = idx + 4'd1;
            end
         end
         rwsp_pkg::PH_HDR: begin
            if (idx < 4) tag = {b, tag[31:8]};
            else remaining = {b, remaining[31:8]};
            if (idx >= 7) begin
               hdr_idx = '0;
               if (tag == rwsp_pkg::TAG_FMT) begin
                  fmt_tag = '0;
                  chans = '0;
                  rate = '0;
                  align = '0;
                  fmt_seen = 1'b1;
               end else if (tag == rwsp_pkg::TAG_DATA) begin
                  if (!fmt_seen)
                     add_result(rwsp_pkg::EV_NO_FMT, 8'd0, 32'd0);
                  else if (fmt_tag != rwsp_pkg::FORMAT_PCM)
                     add_result(rwsp_pkg::EV_BAD_TAG, 8'd0, 32'd0);
                  else if (chans != rwsp_pkg::NEEDED_CHANNELS)
                     add_result(rwsp_pkg::EV_BAD_CHANNELS, 8'd0, 32'd0);
                  else if (align[15:1] != rwsp_pkg::NEEDED_HALF_ALIGN)
                     add_result(rwsp_pkg::EV_BAD_BITS, 8'd0, 32'd0);
                  else begin
                     add_result(rwsp_pkg::EV_PLAY_START, 8'd0, rate);
                     playing = 1'b1;
                  end
               end
               if (remaining == 0) close_chunk();
               else phase = rwsp_pkg::PH_BODY;
            end else begin
               hdr_idx = idx + 4'd1;
            end
         end
         default: begin
            if (tag == rwsp_pkg::TAG_FMT) begin
               if (idx < 2) fmt_tag = fmt_tag | (16'(b) << (8 * idx));
               else if (idx < 4) chans = chans | (16'(b) << (8 * (idx - 2)));
               else if (idx < 8) rate = rate | (32'(b) << (8 * (idx - 4)));
               else if (idx == 12 || idx == 13) align = align | (16'(b) << (8 * (idx - 12)));
            end
            if (playing) add_result(rwsp_pkg::EV_AUDIO, b, 32'd0);
            if (idx < 15) hdr_idx = idx + 4'd1;
            remaining = remaining - 32'd1;
            if (remaining == 0) close_chunk();
         end
      endcase
      if (pending_results.size() > first) begin
         tail = pending_results.pop_back();
         tail.last_of_run = 1'b1;
         pending_results.push_back(tail);
      end
   endfunction

   function void match_result(rwsp_pkg::res_type got);
      rwsp_pkg::res_type want;
      if (pending_results.size() == 0) begin
         $error("result transaction with nothing pending: event_res %0d", got.event_res);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      event_tally[want.event_res]++;
      if (got.event_res !== want.event_res) begin
         $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
         mismatches++;
      end
      if (got.audio_byte !== want.audio_byte) begin
         $error("audio_byte: expected %0h, got %0h", want.audio_byte, got.audio_byte);
         mismatches++;
      end
      if (got.sample_rate !== want.sample_rate) begin
         $error("sample_rate: expected %0h, got %0h", want.sample_rate, got.sample_rate);
         mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
         mismatches++;
      end
   endfunction
endclass

module testbench;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 20;

   typedef enum {CHUNK_FMT, CHUNK_DATA, CHUNK_OTHER} chunk_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_res;
   logic [7:0]  rsp_audio_byte;
   logic [31:0] rsp_sample_rate;
   logic        rsp_last_of_run;

   wave_event_board board;
   logic [7:0]      file_bytes[$];
   int              items_sent = 0;
   int              files_sent = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              cycle_count = 0;

   riff_wave_stream_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_audio_byte  (rsp_audio_byte),
      .rsp_sample_rate (rsp_sample_rate),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // both monitors see pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.match_result({rsp_event_res, rsp_audio_byte, rsp_sample_rate,
                                rsp_last_of_run});
         if (req_valid && req_ready) board.parse_byte(req_in_byte);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_file_bytes();
      foreach (file_bytes[i]) send_byte(file_bytes[i]);
   endtask

   function automatic void put_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd44100;
         3: return 32'd48000;
         default: return $urandom;
      endcase
   endfunction

   function automatic void put_fmt_chunk();
      logic [127:0] std_body;
      logic [15:0]  ftag, chans, align;
      int           len;
      ftag = rwsp_pkg::FORMAT_PCM;
      chans = rwsp_pkg::NEEDED_CHANNELS;
      align = 16'(4 + $urandom_range(1));
      case ($urandom_range(11))
         0: ftag = ($urandom_range(1) != 0) ? 16'h0003 : 16'($urandom);
         1: chans = ($urandom_range(1) != 0) ? 16'd1 : 16'($urandom);
         2: align = ($urandom_range(1) != 0) ? 16'($urandom_range(3)) : 16'($urandom);
         default: ;
      endcase
      std_body = {16'd16, align, 32'($urandom), pick_rate(), chans, ftag};
      case ($urandom_range(9))
         0: len = $urandom_range(15);
         1: len = $urandom_range(40, 17);
         default: len = 16;
      endcase
      put_le(rwsp_pkg::TAG_FMT, 4);
      put_le(32'(len), 4);
      for (int i = 0; i < len; i++)
         file_bytes.push_back(i < 16 ? std_body[8 * i +: 8] : 8'($urandom));
   endfunction

   function automatic void put_plain_chunk(input logic [31:0] id, input int max_len);
      int len;
      len = ($urandom_range(6) == 0) ? 0 : $urandom_range(max_len, 1);
      put_le(id, 4);
      put_le(32'(len), 4);
      repeat (len) file_bytes.push_back(8'($urandom));
   endfunction

   task automatic send_wave_file();
      chunk_kind_type kinds[$];
      int          chunk_start, last_len;
      logic [31:0] riff_len;
      file_bytes.delete();
      put_le(rwsp_pkg::TAG_RIFF, 4);
      put_le(32'd0, 4);
      put_le(rwsp_pkg::TAG_WAVE, 4);
      if ($urandom_range(99) < 80) begin
         if ($urandom_range(3) == 0) kinds.push_back(CHUNK_OTHER);
         kinds.push_back(CHUNK_FMT);
         if ($urandom_range(3) == 0) kinds.push_back(CHUNK_OTHER);
         kinds.push_back(CHUNK_DATA);
         if ($urandom_range(4) == 0) kinds.push_back(CHUNK_DATA);
      end else begin
         repeat ($urandom_range(4)) kinds.push_back(chunk_kind_type'($urandom_range(2)));
      end
      last_len = 0;
      foreach (kinds[k]) begin
         chunk_start = file_bytes.size();
         case (kinds[k])
            CHUNK_FMT:  put_fmt_chunk();
            CHUNK_DATA: put_plain_chunk(rwsp_pkg::TAG_DATA,
                                        ($urandom_range(9) == 0) ? 120 : 24);
            default:    put_plain_chunk($urandom, 12);
         endcase
         last_len = file_bytes.size() - chunk_start;
      end
      // the RIFF end lands inside the last chunk, so the file closes there
      if (last_len == 0) riff_len = $urandom_range(4);
      else riff_len = 32'(file_bytes.size() - 8 - int'($urandom_range(last_len - 1)));
      for (int i = 0; i < 4; i++) file_bytes[4 + i] = riff_len[8 * i +: 8];
      send_file_bytes();
      files_sent++;
   endtask

   initial begin
      int    closing;
      int    directed_items;
      string closing_note;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // data chunk of size zero before any fmt, closing the file on the same byte
      file_bytes.delete();
      put_le(rwsp_pkg::TAG_RIFF, 4);
      put_le(32'd12, 4);
      put_le(rwsp_pkg::TAG_WAVE, 4);
      put_le(rwsp_pkg::TAG_DATA, 4);
      put_le(32'd0, 4);
      send_file_bytes();
      files_sent++;
      directed_items = items_sent;

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 35;
               recv_stall_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_stall_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         while (items_sent < directed_items + RANDOM_ITEMS * (p + 1) / 3) send_wave_file();
      end

      // a stop error or an endless file can only come last
      closing = $urandom_range(2);
      file_bytes.delete();
      case (closing)
         0: begin
            closing_note = "bad RIFF tag";
            put_le(rwsp_pkg::TAG_RIFF ^
                   (32'($urandom_range(255, 1)) << (8 * $urandom_range(3))), 4);
            repeat (8) file_bytes.push_back(8'($urandom));
            send_file_bytes();
         end
         1: begin
            closing_note = "bad WAVE tag";
            put_le(rwsp_pkg::TAG_RIFF, 4);
            put_le($urandom, 4);
            put_le(rwsp_pkg::TAG_WAVE ^
                   (32'($urandom_range(255, 1)) << (8 * $urandom_range(3))), 4);
            repeat (8) file_bytes.push_back(8'($urandom));
            send_file_bytes();
         end
         default: begin
            closing_note = "RIFF size too large to ever end";
            put_le(rwsp_pkg::TAG_RIFF, 4);
            put_le(32'hFFFF_FFF8 | 32'($urandom_range(7)), 4);
            put_le(rwsp_pkg::TAG_WAVE, 4);
            put_fmt_chunk();
            put_plain_chunk(rwsp_pkg::TAG_DATA, 24);
            send_file_bytes();
         end
      endcase

      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d files: %0d audio, %0d play starts, %0d file ends",
               board.bytes_seen, files_sent, board.event_tally[rwsp_pkg::EV_AUDIO],
               board.event_tally[rwsp_pkg::EV_PLAY_START],
               board.event_tally[rwsp_pkg::EV_FILE_END]);
      $display("format errors: tag %0d, channels %0d, align %0d, no fmt %0d; closed with %s",
               board.event_tally[rwsp_pkg::EV_BAD_TAG],
               board.event_tally[rwsp_pkg::EV_BAD_CHANNELS],
               board.event_tally[rwsp_pkg::EV_BAD_BITS],
               board.event_tally[rwsp_pkg::EV_NO_FMT], closing_note);
      if (board.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/rwsp_pkg.sv
rtl/rwsp_parser.sv
rtl/rwsp_res_queue.sv
rtl/riff_wave_stream_parser.sv
test/testbench.sv
